>>> hdl/wsfd_pkg.sv
package wsfd_pkg;

    // Width of the payload length counter; the usable limit is
    // min(max_payload_len, 2^LEN_BITS - 1).
    localparam int LEN_BITS = 32;

    localparam logic [63:0] LEN_CAP64 = (LEN_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                      : ((64'd1 << LEN_BITS) - 64'd1);
    localparam logic [31:0] LEN_CAP   = (LEN_CAP64 > 64'h0000_0000_FFFF_FFFF)
                                      ? 32'hFFFF_FFFF : LEN_CAP64[31:0];

    localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_CNT = 3'd1;
    localparam logic [2:0] EXT64_CNT = 3'd7;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_DATA,
        PH_ERR
    } phase_t;

    typedef enum logic [1:0] {
        K_HDR  = 2'd0,
        K_DATA = 2'd1,
        K_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        was_masked;
        logic [31:0] payload_len;
        logic [7:0]  data_byte;
        logic        last;
    } res_t;

endpackage

>>> hdl/wsfd_if.sv
interface wsfd_rx_if;
    import wsfd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfd_res_if;
    import wsfd_pkg::*;

    logic        valid;
    logic        ready;
    kind_t       kind;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [31:0] payload_len;
    logic [7:0]  data_byte;
    logic        last;

    modport source (output valid, output kind, output fin_flag, output frame_opcode,
                    output was_masked, output payload_len, output data_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input fin_flag, input frame_opcode,
                    input was_masked, input payload_len, input data_byte,
                    input last, output ready);
endinterface

interface wsfd_cfg_if;
    import wsfd_pkg::*;

    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/wsfd_core.sv
module wsfd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             beat_acc,
    input  logic [7:0]       rx_byte,
    input  logic [31:0]      max_len,
    output logic             res_valid,
    output wsfd_pkg::res_t   res
);
    import wsfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  ext_cnt_reg, ext_cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic        high_reg, high_next;     // length bits above 31 seen
    logic [31:0] rem_reg, rem_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic        masked_reg, masked_next;

    logic [6:0]  len7;
    logic [31:0] ext_acc;
    logic        ext_high;
    logic [31:0] chk_acc;
    logic        chk_high;
    logic        chk_masked;
    logic [31:0] limit;
    logic        over;
    logic [7:0]  key_byte;

    // length check shared by the 7-bit and extended paths
    always_comb
    begin
        len7       = rx_byte[6:0];
        ext_acc    = {acc_reg[23:0], rx_byte};
        ext_high   = high_reg | (acc_reg[31:24] != 8'd0);
        chk_acc    = (phase_reg == PH_HDR1) ? {25'd0, len7} : ext_acc;
        chk_high   = (phase_reg == PH_HDR1) ? 1'b0 : ext_high;
        chk_masked = (phase_reg == PH_HDR1) ? rx_byte[7] : masked_reg;
        limit      = (max_len < LEN_CAP) ? max_len : LEN_CAP;
        over       = chk_high || (chk_acc > limit);
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR0: phase_next = PH_HDR1;
            PH_HDR1, PH_EXT:
            begin
                if ((phase_reg == PH_HDR1 && (len7 == LEN7_EXT16 || len7 == LEN7_EXT64))
                    || (phase_reg == PH_EXT && ext_cnt_reg != 3'd0))
                    phase_next = PH_EXT;
                else if (over)
                    phase_next = PH_ERR;
                else if (chk_masked)
                    phase_next = PH_MASK;
                else if (chk_acc == 32'd0)
                    phase_next = PH_HDR0;
                else
                    phase_next = PH_DATA;
            end
            PH_MASK:
            begin
                if (idx_reg == 2'd3)
                    phase_next = (acc_reg == 32'd0) ? PH_HDR0 : PH_DATA;
            end
            PH_DATA:
            begin
                if (rem_reg == 32'd1)
                    phase_next = PH_HDR0;
            end
            PH_ERR:  phase_next = PH_ERR;
            default: phase_next = PH_HDR0;
        endcase
    end

    // datapath and result
    always_comb
    begin
        ext_cnt_next     = ext_cnt_reg;
        acc_next         = acc_reg;
        high_next        = high_reg;
        rem_next         = rem_reg;
        key_next         = key_reg;
        idx_next         = idx_reg;
        fin_next         = fin_reg;
        op_next          = op_reg;
        masked_next      = masked_reg;
        res_valid        = 1'b0;
        res.kind         = K_HDR;
        res.fin_flag     = fin_reg;
        res.frame_opcode = op_reg;
        res.was_masked   = masked_reg;
        res.payload_len  = acc_reg;
        res.data_byte    = 8'd0;
        res.last         = 1'b0;
        case (phase_reg)
            PH_HDR0:
            begin
                fin_next = rx_byte[7];
                op_next  = rx_byte[3:0];
            end
            PH_HDR1, PH_EXT:
            begin
                res.was_masked = chk_masked;
                if (phase_reg == PH_HDR1)
                    masked_next = rx_byte[7];
                if (phase_reg == PH_HDR1 && len7 == LEN7_EXT16)
                begin
                    ext_cnt_next = EXT16_CNT;
                    acc_next     = 32'd0;
                    high_next    = 1'b0;
                end
                else if (phase_reg == PH_HDR1 && len7 == LEN7_EXT64)
                begin
                    ext_cnt_next = EXT64_CNT;
                    acc_next     = 32'd0;
                    high_next    = 1'b0;
                end
                else if (phase_reg == PH_EXT && ext_cnt_reg != 3'd0)
                begin
                    ext_cnt_next = ext_cnt_reg - 3'd1;
                    acc_next     = ext_acc;
                    high_next    = ext_high;
                end
                else
                begin
                    acc_next  = chk_acc;
                    high_next = chk_high;
                    if (over)
                    begin
                        res_valid       = 1'b1;
                        res.kind        = K_ERR;
                        res.payload_len = chk_high ? 32'hFFFF_FFFF : chk_acc;
                    end
                    else if (chk_masked)
                    begin
                        key_next = 32'd0;
                        idx_next = 2'd0;
                    end
                    else
                    begin
                        rem_next        = chk_acc;
                        idx_next        = 2'd0;
                        res_valid       = 1'b1;
                        res.payload_len = chk_acc;
                        res.last        = (chk_acc == 32'd0);
                    end
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], rx_byte};
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    rem_next  = acc_reg;
                    res_valid = 1'b1;
                    res.last  = (acc_reg == 32'd0);
                end
            end
            PH_DATA:
            begin
                idx_next      = idx_reg + 2'd1;
                rem_next      = rem_reg - 32'd1;
                res_valid     = 1'b1;
                res.kind      = K_DATA;
                res.data_byte = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                res.last      = (rem_reg == 32'd1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            ext_cnt_reg <= 3'd0;
            acc_reg     <= 32'd0;
            high_reg    <= 1'b0;
            rem_reg     <= 32'd0;
            key_reg     <= 32'd0;
            idx_reg     <= 2'd0;
            fin_reg     <= 1'b0;
            op_reg      <= 4'd0;
            masked_reg  <= 1'b0;
        end
        else if (beat_acc)
        begin
            phase_reg   <= phase_next;
            ext_cnt_reg <= ext_cnt_next;
            acc_reg     <= acc_next;
            high_reg    <= high_next;
            rem_reg     <= rem_next;
            key_reg     <= key_next;
            idx_reg     <= idx_next;
            fin_reg     <= fin_next;
            op_reg      <= op_next;
            masked_reg  <= masked_next;
        end
    end

    a_data_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != 32'd0)
        else $error("payload phase with zero bytes remaining");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR |=> phase_reg == PH_ERR)
        else $error("left error phase without reset");

    a_err_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == K_ERR |-> phase_next == PH_ERR)
        else $error("error result without entering error phase");

    a_data_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == K_DATA |-> phase_reg == PH_DATA)
        else $error("payload result outside payload phase");

endmodule

>>> hdl/websocket_frame_deframer_unit.sv
// Channel  Dir  Beat contents
// rx       in   rx_byte: one byte of the received stream
// res      out  kind, fin_flag, frame_opcode, was_masked, payload_len, data_byte, last
// cfg      in   data: max_payload_len (single register)
//
// One byte per clock unless stalled. Parse state is updated at the rx beat; the
// result (if the byte yields one) lands in the output register on the same edge.
// rx.ready drops only while the output register is full and res is stalled.
// Reset: phase back to header byte 0, limit back to 65536, output empty.
// After a too-large error every later byte is consumed and dropped until reset.
module websocket_frame_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    wsfd_rx_if.sink     rx,
    wsfd_res_if.source  res,
    wsfd_cfg_if.sink    cfg
);
    import wsfd_pkg::*;

    logic [31:0] max_len_reg;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg;
    logic        beat_acc;
    logic        core_valid;
    res_t        core_res;

    // cfg is always writable; the user must write only while idle, the block does not enforce it
    assign cfg.ready = 1'b1;

    // Output register frees up in the same cycle it is drained.
    assign rx.ready = !out_valid_reg || res.ready;
    assign beat_acc = rx.valid && rx.ready;

    wsfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_acc  (beat_acc),
        .rx_byte   (rx.rx_byte),
        .max_len   (max_len_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (beat_acc && core_valid)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_len_reg   <= MAX_LEN_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                max_len_reg <= cfg.data;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (beat_acc && core_valid)
            out_reg <= core_res;
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.fin_flag     = out_reg.fin_flag;
    assign res.frame_opcode = out_reg.frame_opcode;
    assign res.was_masked   = out_reg.was_masked;
    assign res.payload_len  = out_reg.payload_len;
    assign res.data_byte    = out_reg.data_byte;
    assign res.last         = out_reg.last;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> res.valid && !res.ready)
        else $error("rx stalled while output register can take a beat");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        beat_acc && core_valid |=> res.valid)
        else $error("result beat dropped");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !res.valid && !(beat_acc && core_valid) |=> !res.valid)
        else $error("result beat appeared without a source byte");

endmodule
